>>> rtl/core/energy_onset_slicer_defines.svh
// Assertion macros used by the checker file of the onset slicer.
`ifndef ENERGY_ONSET_SLICER_DEFINES_SVH
`define ENERGY_ONSET_SLICER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EOS_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define EOS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/eos_pkg.sv
package eos_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MARKER_BITS     = 16;
  localparam int DEF_MAX_SAMPLES = 65536;
  localparam int DEF_MAX_MARKERS = 64;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS     = 13;
  localparam int WIN_BITS     = 13;
  localparam int OVL_BITS     = 7;
  localparam int LOC_BITS     = 13;
  localparam int SENS_BITS    = 10;
  localparam int OPB_BITS     = SAMPLE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OVERLAP_RATIO = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOCAL_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSITIVITY   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MONO_MODE     = 3'd4;

  localparam logic [WIN_BITS-1:0]  RST_WINDOW_SIZE   = 13'd1024;
  localparam logic [OVL_BITS-1:0]  RST_OVERLAP_RATIO = 7'd2;
  localparam logic [LOC_BITS-1:0]  RST_LOCAL_WINDOW  = 13'd16;
  localparam logic [SENS_BITS-1:0] RST_SENSITIVITY   = 10'd150;

  // Energy is scaled by this percentage base before the threshold compare.
  localparam logic [6:0] THRESH_SCALE = 7'd100;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } eos_op_t;

  typedef struct packed {
    logic    start;
    eos_op_t op;
  } eos_alu_ctl_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_HOP_GO,
    ST_HOP_WAIT,
    ST_PRE_RD,
    ST_PRE_SQL_GO,
    ST_PRE_SQL_WAIT,
    ST_PRE_SQR_GO,
    ST_PRE_SQR_WAIT,
    ST_FRM_CHK,
    ST_FRM_RD,
    ST_FRM_CALC,
    ST_FRM_END,
    ST_ONS_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_M1_GO,
    ST_M1_WAIT,
    ST_M2_GO,
    ST_M2_WAIT,
    ST_SNAP_RD,
    ST_SNAP_CHK,
    ST_REC,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } eos_state_t;

endpackage

>>> rtl/core/eos_ram.sv
module eos_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/eos_alu.sv
module eos_alu import eos_pkg::*; #(
  parameter int UW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  eos_alu_ctl_t        ctl,
  input  logic [UW-1:0]       opa,
  input  logic [OPB_BITS-1:0] opb,
  output logic                done,
  output logic [UW-1:0]       result
);

  localparam int CNT_W = $clog2(UW + 1);

  logic                busy;
  eos_op_t             op_r;
  logic [UW-1:0]       areg;
  logic [UW-1:0]       acc;
  logic [OPB_BITS-1:0] breg;
  logic [OPB_BITS-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic [OPB_BITS:0]   trial;
  logic                fits;

  // Restoring division: one quotient bit per cycle, shifted into areg.
  always_comb begin
    trial = {rem, areg[UW-1]};
    fits  = (trial >= {1'b0, breg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op_r <= ctl.op;
        areg <= opa;
        breg <= opb;
        acc  <= '0;
        rem  <= '0;
        cnt  <= CNT_W'(UW);
      end else if (busy) begin
        if (op_r == ALU_MUL) begin
          // Shift-add multiply; stops as soon as no multiplier bits remain.
          if (breg == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            if (breg[0]) begin
              acc <= acc + areg;
            end
            areg <= areg << 1;
            breg <= breg >> 1;
          end
        end else begin
          if (fits) begin
            rem <= OPB_BITS'(trial - {1'b0, breg});
          end else begin
            rem <= trial[OPB_BITS-1:0];
          end
          areg <= {areg[UW-2:0], fits};
          cnt  <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign result = (op_r == ALU_MUL) ? acc : areg;

endmodule

>>> rtl/core/energy_onset_slicer.sv
// Channel   Direction  Payload
// s_*       in         tdata {right_sample, left_sample}, tlast end_of_clip
// m_*       out        tdata marker_position, tuser overflow, tlast last_marker
// cfg_*     in         register index and write data, one write per cycle
//
// Loading takes one sample per cycle; s_tready stays low from the end-of-clip transfer until
// the analysis ends and, if it found markers, the last marker transfer. One shared serial
// multiply/divide unit does the analysis: the hop divide, two squares per sample, the frame
// energies, a local mean divide and two threshold multiplies per frame, zero crossing search
// steps per onset, then the record of each onset and the output of each marker. Synchronous
// reset returns the block to loading; the sample stores are not cleared.
module energy_onset_slicer import eos_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int MAX_MARKERS = DEF_MAX_MARKERS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [2*SAMPLE_BITS-1:0] s_tdata,  // left_sample, right_sample
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [MARKER_BITS-1:0]  m_tdata,   // marker_position
  output logic                    m_tuser,   // overflow
  output logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = AW + 1;
  localparam int XW  = ((AW > WIN_BITS) ? AW : WIN_BITS) + 2;
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int RW  = SQW + AW;
  localparam int PW  = RW + AW;
  localparam int UW  = RW + ((AW > SENS_BITS) ? AW : SENS_BITS);
  localparam int MCW = $clog2(MAX_MARKERS + 1);
  localparam int LAW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;

  eos_state_t state, state_next;

  logic [WIN_BITS-1:0]  cfg_window;
  logic [OVL_BITS-1:0]  cfg_overlap;
  logic [LOC_BITS-1:0]  cfg_local;
  logic [SENS_BITS-1:0] cfg_sens;
  logic                 cfg_mono;

  logic [CW-1:0]   count;
  logic            dropped;
  logic            armed;
  logic            lost;
  logic [WIN_BITS-1:0] hop;
  logic [AW-1:0]   k;
  logic [AW-1:0]   lo;
  logic [RW-1:0]   racc;
  logic [SQW-1:0]  sq_left;
  logic [XW-1:0]   s;
  logic [CW-1:0]   f;
  logic [PW-1:0]   pacc;
  logic [CW-1:0]   i_idx;
  logic [UW-1:0]   mean;
  logic [UW-1:0]   prod;
  logic [RW-1:0]   e_reg;
  logic [MCW-1:0]  cnt;
  logic [MCW-1:0]  r_idx;
  logic            out_valid;
  logic [MARKER_BITS-1:0] out_pos;
  logic            out_ovf;
  logic            out_last;

  // Memory and unit connections
  logic                    smp_we;
  logic [SAMPLE_BITS-1:0]  l_rd_a, l_rd_b, r_rd_a;
  logic                    run_we;
  logic [RW-1:0]           run_wdata, run_rd_a, run_rd_b;
  logic                    pre_we;
  logic [PW-1:0]           pre_wdata, pre_rd_a, pre_rd_b;
  logic                    lst_we;
  logic [LAW-1:0]          lst_waddr;
  logic [MARKER_BITS-1:0]  lst_wdata, lst_rd;
  logic [AW-1:0]           run_ra, run_rb, pre_ra, pre_rb;
  eos_alu_ctl_t            alu_ctl;
  logic [UW-1:0]           alu_opa, alu_result;
  logic [OPB_BITS-1:0]     alu_opb;
  logic                    alu_done;

  // Derived values
  logic [OVL_BITS-1:0]    ov_c;
  logic [LOC_BITS-1:0]    m_c;
  logic [XW-1:0]          sw;
  logic                   frm_more;
  logic [RW-1:0]          energy;
  logic [XW-1:0]          from_x, to_x;
  logic [PW-1:0]          window_sum;
  logic [SAMPLE_BITS-1:0] l_abs, r_abs, r_samp;
  logic                   crossing;
  logic                   early;
  logic                   hit;
  logic                   last_frame;
  logic                   pre_last;
  logic                   snap_edge;
  logic                   has_room;

  always_comb begin
    ov_c     = (cfg_overlap == '0) ? OVL_BITS'(1) : cfg_overlap;
    m_c      = (cfg_local == '0) ? LOC_BITS'(1) : cfg_local;
    sw       = s + XW'(cfg_window);
    frm_more = (sw < XW'(count));
    energy   = ((sw == '0) ? RW'(0) : run_rd_a) - ((s == '0) ? RW'(0) : run_rd_b);

    // Local mean span: clamped to the first or last mean span of frames at the edges.
    if (XW'(i_idx) < XW'(m_c)) begin
      from_x = '0;
      to_x   = XW'(m_c);
    end else if (XW'(i_idx) + XW'(m_c) < XW'(f)) begin
      from_x = XW'(i_idx);
      to_x   = XW'(i_idx) + XW'(m_c);
    end else begin
      from_x = XW'(f) - XW'(m_c);
      to_x   = XW'(f);
    end
    window_sum = pre_rd_a - ((from_x == '0) ? PW'(0) : pre_rd_b);

    l_abs  = l_rd_b[SAMPLE_BITS-1] ? SAMPLE_BITS'(-l_rd_b) : l_rd_b;
    r_samp = cfg_mono ? l_rd_b : r_rd_a;
    r_abs  = r_samp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_samp) : r_samp;

    crossing = ($signed(l_rd_a) > 0 && $signed(l_rd_b) < 0)
            || ($signed(l_rd_a) < 0 && $signed(l_rd_b) > 0)
            || (l_rd_a == '0 && l_rd_b != '0);

    early      = (f == '0) || (XW'(f) < XW'(m_c));
    hit        = (mean != '0) && (alu_result > prod);
    last_frame = ((i_idx + 1'b1) == f);
    pre_last   = ((CW'(k) + 1'b1) == count);
    snap_edge  = (k == '0) || ((CW'(k) + 1'b1) >= count);
    has_room   = (cnt < MCW'(MAX_MARKERS));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:         if (s_tvalid && s_tlast) state_next = ST_HOP_GO;
      ST_HOP_GO:       state_next = ST_HOP_WAIT;
      ST_HOP_WAIT:     if (alu_done) state_next = ST_PRE_RD;
      ST_PRE_RD:       state_next = ST_PRE_SQL_GO;
      ST_PRE_SQL_GO:   state_next = ST_PRE_SQL_WAIT;
      ST_PRE_SQL_WAIT: if (alu_done) state_next = ST_PRE_SQR_GO;
      ST_PRE_SQR_GO:   state_next = ST_PRE_SQR_WAIT;
      ST_PRE_SQR_WAIT: begin
        if (alu_done) state_next = pre_last ? ST_FRM_CHK : ST_PRE_RD;
      end
      ST_FRM_CHK:      state_next = frm_more ? ST_FRM_RD : ST_FRM_END;
      ST_FRM_RD:       state_next = ST_FRM_CALC;
      ST_FRM_CALC:     state_next = ST_FRM_CHK;
      ST_FRM_END:      state_next = early ? ST_OUT_RD : ST_ONS_RD;
      ST_ONS_RD:       state_next = ST_DIV_GO;
      ST_DIV_GO:       state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:     if (alu_done) state_next = ST_M1_GO;
      ST_M1_GO:        state_next = ST_M1_WAIT;
      ST_M1_WAIT:      if (alu_done) state_next = ST_M2_GO;
      ST_M2_GO:        state_next = ST_M2_WAIT;
      ST_M2_WAIT: begin
        if (alu_done) state_next = (hit && !armed) ? ST_SNAP_RD : ST_NEXT;
      end
      ST_SNAP_RD:      state_next = snap_edge ? ST_REC : ST_SNAP_CHK;
      ST_SNAP_CHK: begin
        if (crossing || k <= lo) state_next = ST_REC;
        else                     state_next = ST_SNAP_RD;
      end
      ST_REC:          state_next = ST_NEXT;
      ST_NEXT: begin
        if (!last_frame)      state_next = ST_ONS_RD;
        else if (cnt == '0)   state_next = ST_LOAD;
        else                  state_next = ST_OUT_RD;
      end
      ST_OUT_RD:       state_next = ST_OUT_LD;
      ST_OUT_LD:       state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (m_tready) state_next = out_last ? ST_LOAD : ST_OUT_RD;
      end
      default:         state_next = ST_LOAD;
    endcase
  end

  // Strobes and operand selection
  always_comb begin
    alu_ctl   = '{start: 1'b0, op: ALU_MUL};
    alu_opa   = UW'(l_abs);
    alu_opb   = l_abs;
    smp_we    = 1'b0;
    run_we    = 1'b0;
    run_wdata = racc + RW'(sq_left) + RW'(alu_result[SQW-1:0]);
    pre_we    = 1'b0;
    pre_wdata = pacc + PW'(energy);
    lst_we    = 1'b0;
    lst_waddr = cnt[LAW-1:0];
    lst_wdata = MARKER_BITS'(k);
    run_ra    = AW'(sw - 1'b1);
    run_rb    = AW'(s - 1'b1);
    pre_ra    = AW'(to_x - 1'b1);
    pre_rb    = AW'(from_x - 1'b1);
    unique case (state)
      ST_LOAD: smp_we = s_tvalid && (count < CW'(MAX_SAMPLES));
      ST_HOP_GO: begin
        alu_ctl = '{start: 1'b1, op: ALU_DIV};
        alu_opa = UW'(cfg_window);
        alu_opb = OPB_BITS'(ov_c);
      end
      ST_PRE_SQL_GO: alu_ctl = '{start: 1'b1, op: ALU_MUL};
      ST_PRE_SQR_GO: begin
        alu_ctl = '{start: 1'b1, op: ALU_MUL};
        alu_opa = UW'(r_abs);
        alu_opb = r_abs;
      end
      ST_PRE_SQR_WAIT: run_we = alu_done;
      ST_FRM_CALC:     pre_we = 1'b1;
      ST_FRM_END: begin
        lst_we    = early;
        lst_waddr = '0;
        lst_wdata = '0;
      end
      ST_DIV_GO: begin
        alu_ctl = '{start: 1'b1, op: ALU_DIV};
        alu_opa = UW'(window_sum);
        alu_opb = OPB_BITS'(m_c);
      end
      ST_M1_GO: begin
        alu_ctl = '{start: 1'b1, op: ALU_MUL};
        alu_opa = mean;
        alu_opb = OPB_BITS'(cfg_sens);
      end
      ST_M2_GO: begin
        alu_ctl = '{start: 1'b1, op: ALU_MUL};
        alu_opa = UW'(e_reg);
        alu_opb = OPB_BITS'(THRESH_SCALE);
      end
      ST_REC: lst_we = has_room;
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_window  <= RST_WINDOW_SIZE;
      cfg_overlap <= RST_OVERLAP_RATIO;
      cfg_local   <= RST_LOCAL_WINDOW;
      cfg_sens    <= RST_SENSITIVITY;
      cfg_mono    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:   cfg_window  <= cfg_data[WIN_BITS-1:0];
        REG_OVERLAP_RATIO: cfg_overlap <= cfg_data[OVL_BITS-1:0];
        REG_LOCAL_WINDOW:  cfg_local   <= cfg_data[LOC_BITS-1:0];
        REG_SENSITIVITY:   cfg_sens    <= cfg_data[SENS_BITS-1:0];
        REG_MONO_MODE:     cfg_mono    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      armed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (count < CW'(MAX_SAMPLES)) count <= count + 1'b1;
            else                          dropped <= 1'b1;
          end
        end
        ST_HOP_GO: begin
          cnt   <= '0;
          lost  <= 1'b0;
          r_idx <= '0;
        end
        ST_HOP_WAIT: begin
          if (alu_done) begin
            hop  <= (alu_result == '0) ? WIN_BITS'(1) : alu_result[WIN_BITS-1:0];
            k    <= '0;
            racc <= '0;
            s    <= '0;
            f    <= '0;
            pacc <= '0;
          end
        end
        ST_PRE_SQL_WAIT: if (alu_done) sq_left <= alu_result[SQW-1:0];
        ST_PRE_SQR_WAIT: begin
          if (alu_done) begin
            racc <= run_wdata;
            k    <= k + 1'b1;
          end
        end
        ST_FRM_CALC: begin
          pacc <= pre_wdata;
          f    <= f + 1'b1;
          s    <= s + XW'(hop);
        end
        ST_FRM_END: begin
          if (early) begin
            cnt <= MCW'(1);
          end
          i_idx <= '0;
          s     <= '0;
          armed <= 1'b0;
        end
        ST_DIV_GO:   e_reg <= energy;
        ST_DIV_WAIT: if (alu_done) mean <= alu_result;
        ST_M1_WAIT:  if (alu_done) prod <= alu_result;
        ST_M2_WAIT: begin
          if (alu_done) begin
            if (!hit) begin
              armed <= 1'b0;
            end else if (!armed) begin
              armed <= 1'b1;
              k     <= AW'(s);
              lo    <= (s > XW'(cfg_window)) ? AW'(s - XW'(cfg_window)) : '0;
            end
          end
        end
        ST_SNAP_CHK: if (!crossing && k > lo) k <= k - 1'b1;
        ST_REC: begin
          if (has_room) cnt  <= cnt + 1'b1;
          else          lost <= 1'b1;
        end
        ST_NEXT: begin
          i_idx <= i_idx + 1'b1;
          s     <= s + XW'(hop);
          if (last_frame && cnt == '0) begin
            count   <= '0;
            dropped <= 1'b0;
            armed   <= 1'b0;
          end
        end
        ST_OUT_LD: begin
          out_pos   <= lst_rd;
          out_ovf   <= dropped || lost;
          out_last  <= ((r_idx + 1'b1) == cnt);
          out_valid <= 1'b1;
        end
        ST_OUT_WAIT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            r_idx     <= r_idx + 1'b1;
            if (out_last) begin
              count   <= '0;
              dropped <= 1'b0;
              armed   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  eos_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(SAMPLE_BITS), .ADDR_W(AW)) u_left (
    .clk     (clk),
    .we      (smp_we),
    .waddr   (count[AW-1:0]),
    .wdata   (s_tdata[SAMPLE_BITS-1:0]),
    .raddr_a (AW'(k - 1'b1)),
    .raddr_b (k),
    .rdata_a (l_rd_a),
    .rdata_b (l_rd_b)
  );

  eos_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(SAMPLE_BITS), .ADDR_W(AW)) u_right (
    .clk     (clk),
    .we      (smp_we),
    .waddr   (count[AW-1:0]),
    .wdata   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .raddr_a (k),
    .raddr_b (k),
    .rdata_a (r_rd_a),
    .rdata_b ()
  );

  // Running energy over samples; entry j holds the sum up to and including sample j.
  eos_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(RW), .ADDR_W(AW)) u_running (
    .clk     (clk),
    .we      (run_we),
    .waddr   (k),
    .wdata   (run_wdata),
    .raddr_a (run_ra),
    .raddr_b (run_rb),
    .rdata_a (run_rd_a),
    .rdata_b (run_rd_b)
  );

  // Running energy over frames, same offset by one.
  eos_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(PW), .ADDR_W(AW)) u_prefix (
    .clk     (clk),
    .we      (pre_we),
    .waddr   (f[AW-1:0]),
    .wdata   (pre_wdata),
    .raddr_a (pre_ra),
    .raddr_b (pre_rb),
    .rdata_a (pre_rd_a),
    .rdata_b (pre_rd_b)
  );

  eos_ram #(.DEPTH(MAX_MARKERS), .WIDTH(MARKER_BITS), .ADDR_W(LAW)) u_markers (
    .clk     (clk),
    .we      (lst_we),
    .waddr   (lst_waddr),
    .wdata   (lst_wdata),
    .raddr_a (r_idx[LAW-1:0]),
    .raddr_b (r_idx[LAW-1:0]),
    .rdata_a (lst_rd),
    .rdata_b ()
  );

  eos_alu #(.UW(UW)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .opa    (alu_opa),
    .opb    (alu_opb),
    .done   (alu_done),
    .result (alu_result)
  );

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_pos;
  assign m_tuser  = out_ovf;
  assign m_tlast  = out_last;

endmodule

>>> rtl/core/eos_checker.sv
`include "energy_onset_slicer_defines.svh"

module eos_checker import eos_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [MARKER_BITS-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  // A stalled marker keeps its payload.
  `EOS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Markers are only delivered while loading is closed.
  `EOS_ASSERT_SAME(a_no_load_during_out, clk, rst, m_tvalid, !s_tready)

  // The final marker transfer reopens the input.
  `EOS_ASSERT_NEXT(a_reopen_after_last, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)

  // A sample that does not end the clip keeps the input open.
  `EOS_ASSERT_NEXT(a_load_continues, clk, rst, s_tvalid && s_tready && !s_tlast, s_tready && !m_tvalid)

endmodule

bind energy_onset_slicer eos_checker u_eos_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import eos_pkg::*;

  typedef struct {
    logic [MARKER_BITS-1:0] position;
    logic                   overflow;
    logic                   last;
  } marker_t;

  class onset_scoreboard;
    logic [WIN_BITS-1:0]  win_len   = RST_WINDOW_SIZE;
    logic [OVL_BITS-1:0]  hop_div   = RST_OVERLAP_RATIO;
    logic [LOC_BITS-1:0]  mean_span = RST_LOCAL_WINDOW;
    logic [SENS_BITS-1:0] sensitivity = RST_SENSITIVITY;
    logic                 mono_mode   = 1'b0;

    longint left_clip[$];
    longint right_clip[$];
    bit     samples_dropped;
    marker_t pending_markers[$];
    int     errors;
    int     markers_seen;
    int     clips_done;

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_WINDOW_SIZE:   win_len     = val[WIN_BITS-1:0];
        REG_OVERLAP_RATIO: hop_div     = val[OVL_BITS-1:0];
        REG_LOCAL_WINDOW:  mean_span   = val[LOC_BITS-1:0];
        REG_SENSITIVITY:   sensitivity = val[SENS_BITS-1:0];
        REG_MONO_MODE:     mono_mode   = val[0];
        default: ;
      endcase
    endfunction

    function bit is_crossing(longint k, longint n);
      longint a, b;
      if (k == 0 || k + 1 >= n) return 1;
      a = left_clip[k-1];
      b = left_clip[k];
      return (a > 0 && b < 0) || (a < 0 && b > 0) || (a == 0 && b != 0);
    endfunction

    function longint snap_back(longint idx, longint reach, longint n);
      longint lo, k;
      if (idx == 0) return 0;
      lo = (idx > reach) ? idx - reach : 0;
      k = idx;
      while (!is_crossing(k, n) && k > lo) k--;
      return k;
    endfunction

    // Runs the onset search over the clip loaded so far and queues its markers.
    function void analyze_clip();
      longint n, w, hop, m, frames, i, s, mean, from, upto, lpos, r;
      longint unsigned prefix[$];
      longint unsigned energy[$];
      longint positions[$];
      bit armed, lost;
      marker_t mk;
      n = left_clip.size();
      w = win_len;
      hop = w / ((hop_div == 0) ? 1 : hop_div);
      if (hop == 0) hop = 1;
      m = (mean_span == 0) ? 1 : mean_span;
      lost = 0;
      prefix = {prefix, longint'(0)};
      for (i = 0; i < n; i++) begin
        r = mono_mode ? left_clip[i] : right_clip[i];
        prefix = {prefix, prefix[i] + left_clip[i] * left_clip[i] + r * r};
      end
      for (s = 0; s + w < n; s += hop) energy = {energy, prefix[s+w] - prefix[s]};
      frames = energy.size();
      armed = 0;
      if (frames == 0 || frames < m) begin
        positions = {positions, longint'(0)};
      end else begin
        prefix.delete();
        prefix = {prefix, longint'(0)};
        for (i = 0; i < frames; i++) prefix = {prefix, prefix[i] + energy[i]};
        for (i = 0; i < frames; i++) begin
          if (i < m) begin
            from = 0; upto = m;
          end else if (i + m < frames) begin
            from = i; upto = i + m;
          end else begin
            from = frames - m; upto = frames;
          end
          mean = (prefix[upto] - prefix[from]) / m;
          if (mean > 0 && energy[i] * 100 > sensitivity * mean) begin
            if (!armed) begin
              lpos = snap_back(i * hop, w, n);
              if (positions.size() < DEF_MAX_MARKERS) positions = {positions, lpos};
              else lost = 1;
              armed = 1;
            end
          end else begin
            armed = 0;
          end
        end
      end
      foreach (positions[j]) begin
        mk.position = positions[j][MARKER_BITS-1:0];
        mk.overflow = samples_dropped || lost;
        mk.last     = (j == positions.size() - 1);
        pending_markers = {pending_markers, mk};
      end
      left_clip.delete();
      right_clip.delete();
      samples_dropped = 0;
      clips_done++;
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] l,
                              logic signed [SAMPLE_BITS-1:0] r, logic end_of_clip);
      if (left_clip.size() < DEF_MAX_SAMPLES) begin
        left_clip = {left_clip, longint'(l)};
        right_clip = {right_clip, longint'(r)};
      end else begin
        samples_dropped = 1;
      end
      if (end_of_clip) analyze_clip();
    endfunction

    function void check_marker(logic [MARKER_BITS-1:0] pos, logic ovf, logic lst);
      marker_t want;
      markers_seen++;
      if (pending_markers.size() == 0) begin
        $error("marker %0d arrived with none expected", pos);
        errors++;
        return;
      end
      want = pending_markers.pop_front();
      if (pos !== want.position) begin
        $error("marker_position: expected %0d, got %0d", want.position, pos);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, ovf);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last_marker: expected %0b, got %0b", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [2*SAMPLE_BITS-1:0]  s_tdata;   // left_sample, right_sample
  logic                      s_tlast;   // end_of_clip
  logic                      m_tvalid;
  logic                      m_tready;
  logic [MARKER_BITS-1:0]    m_tdata;   // marker_position
  logic                      m_tuser;   // overflow
  logic                      m_tlast;   // last_marker
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  onset_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int samples_sent;

  energy_onset_slicer i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_marker(m_tdata, m_tuser, m_tlast);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_BITS-1:0];
    @(posedge clk);
    sb.set_reg(idx, val[CFG_BITS-1:0]);
  endtask

  task automatic configure(int win, int ovl, int loc, int sens, int mono);
    write_reg(REG_WINDOW_SIZE, win);
    write_reg(REG_OVERLAP_RATIO, ovl);
    write_reg(REG_LOCAL_WINDOW, loc);
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_MONO_MODE, mono);
    cfg_we <= 1'b0;
  endtask

  // A clip ends in an analysis pass that may yield nothing, so idle means every
  // marker is in and the block takes samples again. The first edge lets s_tready
  // show the state after the end-of-clip transfer.
  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending_markers.size() != 0 || !s_tready) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_clip(longint lq[$], longint rq[$]);
    logic [SAMPLE_BITS-1:0] l, r;
    foreach (lq[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      l = SAMPLE_BITS'(lq[i]);
      r = SAMPLE_BITS'(rq[i]);
      s_tvalid <= 1'b1;
      s_tdata  <= {r, l};
      s_tlast  <= (i == lq.size() - 1);
      do @(posedge clk); while (!s_tready);
      sb.note_sample(l, r, i == lq.size() - 1);
      samples_sent++;
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
  endtask

  function automatic longint pick_sample(int style);
    case (style)
      0: return $signed(16'($urandom_range(6))) - 3;
      1: return $signed(16'($urandom));
      2: return ($urandom_range(1)) ? 32767 : -32768;
      default: return 0;
    endcase
  endfunction

  // Quiet stretches with loud bursts, so the onset search finds edges.
  task automatic random_clip(int len);
    longint lq[$], rq[$];
    int style;
    style = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(5) == 0) style = $urandom_range(3);
      lq = {lq, pick_sample(style)};
      rq = {rq, pick_sample($urandom_range(3) == 0 ? 1 : style)};
    end
    send_clip(lq, rq);
  endtask

  initial begin
    longint lq[$], rq[$];
    int clip_no, win, ovl, loc, sens;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; samples_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings with a one-sample clip: too few frames, single marker 0.
    lq = '{0}; rq = '{5};
    send_clip(lq, rq);
    wait_idle();

    // Field extremes and zero crossings, threshold zero.
    configure(2, 1, 2, 0, 0);
    lq = '{0, 32767, -32768, 0, 0, 0, 100, -100, 32767, 0};
    rq = '{-32768, 32767, 0, 0, 0, 0, 0, 0, -32768, 0};
    send_clip(lq, rq);
    wait_idle();

    // Highest threshold, mono, widest hop divisor.
    configure(4, 64, 1, 1000, 1);
    lq = '{0, 0, 0, 0, 0, 9, -9, 32767, -32768, 0, 0, 0};
    rq = '{32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0};
    send_clip(lq, rq);
    wait_idle();

    // Widest window and local mean: no frame fits, marker 0.
    configure(4096, 1, 4096, 500, 0);
    lq = '{1, -1, 1}; rq = '{1, 1, 1};
    send_clip(lq, rq);
    wait_idle();

    clip_no = 0;
    while (samples_sent < 200) begin
      case (clip_no % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (clip_no == 3) begin
        // Alternating silence and sound gives an onset every other frame,
        // more than the marker list holds.
        configure(1, 1, 1, 50, 0);
        lq.delete(); rq.delete();
        for (int i = 0; i < 136; i++) begin
          lq = {lq, (i % 2) ? longint'($urandom_range(32767, 1000)) : longint'(0)};
          rq = {rq, longint'(0)};
        end
        send_clip(lq, rq);
      end else begin
        win  = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(12, 1);
        ovl  = ($urandom_range(7) == 0) ? $urandom_range(64, 1) : $urandom_range(4, 1);
        loc  = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(6, 1);
        sens = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 1000 : 0)
                                        : $urandom_range(300, 50);
        configure(win, ovl, loc, sens, $urandom_range(1));
        random_clip($urandom_range(48, 1));
      end
      wait_idle();
      clip_no++;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d clips with %0d samples and checked %0d markers,",
             sb.clips_done, samples_sent, sb.markers_seen);
    $display("covering idle/stall phases, mono, marker overflow and short clips.");
    if (sb.errors == 0 && sb.pending_markers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending_markers.size() != 0)
        $error("%0d expected markers never arrived", sb.pending_markers.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
